// ===== rtl/stack_with_bottom_insert_and_delete_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bottom-insert stack
// Clocked on i_clk; the first form is held off during reset, the second is not.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_BOTTOM_INSERT_AND_DELETE_ASSERT_SVH
`define STACK_WITH_BOTTOM_INSERT_AND_DELETE_ASSERT_SVH

// Check a property outside reset
`define SWBID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define SWBID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/swbid_pkg.sv =====
// ----------------------------------------------------------------------------
// swbid_pkg
// Types and constants shared by the stack cells and the top level.
// ----------------------------------------------------------------------------
package swbid_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int FILL_W = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_INS_BOT = 2'd2,
        FUNC_DELETE  = 2'd3
    } t_func;

    typedef struct packed {
        t_func func;
        t_word value;
    } t_in_beat;

    typedef struct packed {
        logic              applied;
        logic [FILL_W-1:0] fill_count;
        t_word             top_word;
        logic              is_empty;
        logic              is_full;
    } t_out_beat;

    // Contents of one cell as seen by its neighbours
    typedef struct packed {
        logic  valid;
        t_word data;
    } t_link;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic  en;
        t_func func;
        t_word value;
    } t_cell_ctrl;

endpackage

// ===== rtl/stack_with_bottom_insert_and_delete.sv =====
// ----------------------------------------------------------------------------
// stack_with_bottom_insert_and_delete
// Fixed-depth signed word stack with push, pop, insert at bottom and delete
// by value, built as a row of cells that shift into one another.
// ----------------------------------------------------------------------------
// Each input beat carries one operation and is applied to the row of DEPTH
// cells at the edge that accepts it; its result beat (applied flag, fill
// count, top word, empty and full) moves into the output register once it is
// free. A new operation is taken in the same cycle as the previous result
// moves into the output register, so the block sustains one operation per
// cycle while results are taken. While the output side stalls, one result
// waits in the output register and the next waits behind it in the cells,
// and input is held until the output register frees; input then runs at the
// rate at which results are taken. The delete search and the top-word pick
// run as chains through all cells, which set the critical path. No clearing
// pass after reset: only the occupied flags are cleared.
// ----------------------------------------------------------------------------
`include "stack_with_bottom_insert_and_delete_assert.svh"

module stack_with_bottom_insert_and_delete (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  swbid_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output swbid_pkg::t_out_beat o_out_beat
);
    import swbid_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    logic             r_applied;
    logic             r_out_valid;
    t_out_beat        r_out;

    t_link      w_link   [DEPTH];
    t_link      w_below  [DEPTH];
    t_link      w_above  [DEPTH];
    logic       w_ge     [DEPTH+1];
    logic       w_hit    [DEPTH+1];
    t_word      w_top    [DEPTH+1];
    logic [DEPTH-1:0] w_valid;
    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_load;
    logic       w_applied;
    logic       w_full;
    logic       w_empty;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_load     = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend || w_load;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ge[DEPTH]  = 1'b0;
    assign w_hit[DEPTH] = 1'b0;
    assign w_top[DEPTH] = '0;

    always_comb begin
        unique case (i_in_beat.func)
            FUNC_PUSH:    w_applied = !w_full;
            FUNC_POP:     w_applied = !w_empty;
            FUNC_INS_BOT: w_applied = !w_full;
            FUNC_DELETE:  w_applied = w_hit[0];
            default:      w_applied = 1'b0;
        endcase
    end

    assign w_ctrl.en    = w_accept && w_applied;
    assign w_ctrl.func  = i_in_beat.func;
    assign w_ctrl.value = i_in_beat.value;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_base
                // the floor counts as occupied and feeds the inserted word
                assign w_below[g].valid = 1'b1;
                assign w_below[g].data  = i_in_beat.value;
            end else begin : g_mid
                assign w_below[g] = w_link[g-1];
            end
            if (g == DEPTH - 1) begin : g_roof
                assign w_above[g].valid = 1'b0;
                assign w_above[g].data  = '0;
            end else begin : g_low
                assign w_above[g] = w_link[g+1];
            end
            assign w_valid[g] = w_link[g].valid;

            swbid_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_below     (w_below[g]),
                .i_above     (w_above[g]),
                .i_ge_above  (w_ge[g+1]),
                .i_hit_above (w_hit[g+1]),
                .i_top_above (w_top[g+1]),
                .o_link      (w_link[g]),
                .o_ge_down   (w_ge[g]),
                .o_hit_down  (w_hit[g]),
                .o_top_down  (w_top[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.en) begin
            unique case (i_in_beat.func)
                FUNC_PUSH, FUNC_INS_BOT: n_count = r_count + 1'b1;
                FUNC_POP, FUNC_DELETE:   n_count = r_count - 1'b1;
                default:                 n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: cells already hold the post-operation state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_applied <= w_applied;
        end
        if (w_load) begin
            r_out.applied    <= r_applied;
            r_out.fill_count <= FILL_W'(r_count);
            r_out.top_word   <= w_top[0];
            r_out.is_empty   <= w_empty;
            r_out.is_full    <= w_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `SWBID_ASSERT(a_count_matches_cells, $countones(w_valid) == r_count, "count differs from occupied cells")
    `SWBID_ASSERT(a_cells_packed, ((w_valid + 1'b1) & w_valid) == '0, "occupied cells not packed at bottom")
    `SWBID_ASSERT(a_pend_held, (r_pend && !w_load) |=> r_pend, "pending result dropped")
    `SWBID_ASSERT(a_empty_flag, o_out_valid |-> (o_out_beat.is_empty == (o_out_beat.fill_count == '0)), "empty flag disagrees with fill count")
    `SWBID_ASSERT_ALWAYS(a_no_out_in_reset, !i_rst_n |=> !o_out_valid, "result beat offered after reset")

endmodule

// ===== rtl/swbid_cell.sv =====
// ----------------------------------------------------------------------------
// swbid_cell
// One stack slot: holds a word and an occupied flag, shifts to or from its
// neighbours and takes part in the top-down search chains.
// ----------------------------------------------------------------------------
module swbid_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swbid_pkg::t_cell_ctrl i_ctrl,
    input  swbid_pkg::t_link      i_below,
    input  swbid_pkg::t_link      i_above,
    input  logic                  i_ge_above,
    input  logic                  i_hit_above,
    input  swbid_pkg::t_word      i_top_above,
    output swbid_pkg::t_link      o_link,
    output logic                  o_ge_down,
    output logic                  o_hit_down,
    output swbid_pkg::t_word      o_top_down
);
    import swbid_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_word r_data;
    t_word n_data;
    logic  w_ge;
    logic  w_eq;

    assign w_ge = r_valid && !(r_data < i_ctrl.value);
    assign w_eq = r_valid && (r_data == i_ctrl.value);

    // The highest entry not below the value is the stop point
    assign o_ge_down  = i_ge_above | w_ge;
    assign o_hit_down = (w_ge && !i_ge_above) ? w_eq : i_hit_above;
    assign o_top_down = (r_valid && !i_above.valid) ? r_data : i_top_above;

    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.en) begin
            unique case (i_ctrl.func)
                FUNC_PUSH: begin
                    if (!r_valid && i_below.valid) begin
                        n_valid = 1'b1;
                        n_data  = i_ctrl.value;
                    end
                end
                FUNC_POP: begin
                    n_valid = r_valid & i_above.valid;
                end
                FUNC_INS_BOT: begin
                    n_valid = i_below.valid;
                    n_data  = i_below.data;
                end
                FUNC_DELETE: begin
                    // close the gap at and above the stop point
                    if (!i_ge_above) begin
                        n_valid = i_above.valid;
                        n_data  = i_above.data;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
